// ===== hdl/mcct_pkg.sv =====
// Package for the countdown timer bank: field widths, opcodes, result kinds
// and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package mcct_pkg;

  // Parameter defaults.
  localparam int unsigned NumTimersDef  = 15;
  localparam int unsigned CountWidthDef = 31;

  // Fixed field widths of the stream items.
  localparam int unsigned OpW    = 2;
  localparam int unsigned IdW    = 5;
  localparam int unsigned TickW  = 31;
  localparam int unsigned KindW  = 2;
  localparam int unsigned MaxCountW = 63;

  // Bus widths, padded to whole bytes.
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  // Request opcodes.
  localparam logic [OpW-1:0] OP_TICK  = 2'd0;
  localparam logic [OpW-1:0] OP_START = 2'd1;
  localparam logic [OpW-1:0] OP_STOP  = 2'd2;
  localparam logic [OpW-1:0] OP_NONE  = 2'd3;

  // Result kinds.
  localparam logic [KindW-1:0] KIND_START  = 2'd0;
  localparam logic [KindW-1:0] KIND_STOP   = 2'd1;
  localparam logic [KindW-1:0] KIND_EXPIRY = 2'd2;

  // One result item as it waits to go out.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             ok;
    logic [IdW-1:0]   id;
    logic             mode;
    logic             last;
  } result_t;

  // Flags from the shared decrement unit.
  typedef struct packed {
    logic diff_zero;
    logic operand_nonzero;
  } dec_flags_t;

endpackage

// ===== hdl/mcct_dec_unit.sv =====
// Shared decrement and zero-detect unit of the timer bank.
// Depends on mcct_pkg.
`timescale 1ns / 1ps

module mcct_dec_unit
  import mcct_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic [COUNT_WIDTH-1:0] operand_i,
  output logic [COUNT_WIDTH-1:0] diff_o,
  output dec_flags_t             flags_o
);

  // Decrement wraps modulo 2**COUNT_WIDTH.
  assign diff_o = operand_i - COUNT_WIDTH'(1);

  // The result is zero exactly when the operand was one.
  assign flags_o.diff_zero       = (operand_i == COUNT_WIDTH'(1));
  assign flags_o.operand_nonzero = (operand_i != '0);

endmodule

// ===== hdl/multi_channel_countdown_timers.sv =====
// Top level of the one-shot countdown timer bank: stream ports, timer
// storage and the scan sequencer. Depends on mcct_pkg and mcct_dec_unit.
`timescale 1ns / 1ps

// A bank of NUM_TIMERS one-shot timers behind one input and one output stream.
// A start or stop request answers with one result. Its answer is registered in
// the holding stage, and the input is ready again once that stage has handed
// it on to the output register. A tick walks the timers in id order through
// one shared decrementer, one timer per cycle unless the scan pauses, and
// the input stays blocked until the scan is over and the final expiry, if
// any timer expired, has left the holding stage. Each timer that reaches zero
// gives one expiry result, the final one with tlast set. Results leave through
// a holding stage and an output register; when both are full and another
// timer expires, the scan pauses until the output side takes a transfer. A
// new request is taken once the holding stage is empty.
module multi_channel_countdown_timers
  import mcct_pkg::*;
#(
  parameter int unsigned NUM_TIMERS  = NumTimersDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // timer_id [4:0], deliver_as_message [5], tick_count [36:6], zeros above
  input  logic [InDataW-1:0]  s_axis_tdata,
  // op [1:0]
  input  logic [OpW-1:0]      s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // ok [0], expired_id [5:1], expired_mode [6], zero [7]
  output logic [OutDataW-1:0] m_axis_tdata,
  // kind [1:0]
  output logic [KindW-1:0]    m_axis_tuser,
  output logic                m_axis_tlast
);

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;
  logic [IdxW-1:0] idx_q;

  logic [COUNT_WIDTH-1:0] rem_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  active_q;
  logic [NUM_TIMERS-1:0]  mode_q;

  result_t pend_q, out_q;
  logic    pend_valid_q, out_valid_q;

  // Request fields.
  logic [IdW-1:0]       req_id;
  logic                 req_mode;
  logic [TickW-1:0]     req_count;
  logic [MaxCountW-1:0] req_count_ext;
  logic [COUNT_WIDTH-1:0] load_count;
  logic                 req_valid;
  logic [IdxW-1:0]      req_idx;

  assign req_id        = s_axis_tdata[IdW-1:0];
  assign req_mode      = s_axis_tdata[IdW];
  assign req_count     = s_axis_tdata[IdW+TickW:IdW+1];
  assign req_count_ext = {{(MaxCountW-TickW){1'b0}}, req_count};
  assign load_count    = req_count_ext[COUNT_WIDTH-1:0];
  assign req_valid     = ({1'b0, req_id} < (IdW+1)'(NUM_TIMERS));
  assign req_idx       = req_id[IdxW-1:0];

  // Read ports: one for the scan position, one for the request id.
  logic [COUNT_WIDTH-1:0] scan_rd, sel_rd, unit_in, unit_diff;
  logic                   scan_act, scan_mode;
  dec_flags_t             unit_flags;

  assign scan_rd   = rem_q[idx_q];
  assign scan_act  = active_q[idx_q];
  assign scan_mode = mode_q[idx_q];
  assign sel_rd    = req_valid ? rem_q[req_idx] : '0;
  assign unit_in   = (state_q == ST_SCAN) ? scan_rd : sel_rd;

  mcct_dec_unit #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dec (
    .operand_i(unit_in),
    .diff_o   (unit_diff),
    .flags_o  (unit_flags)
  );

  // Scan control.
  logic accept, out_free, cand, stall, step, last_step, move;

  assign s_axis_tready = (state_q == ST_IDLE) && !pend_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cand          = (state_q == ST_SCAN) && scan_act && unit_flags.diff_zero;
  assign stall         = cand && pend_valid_q && !out_free;
  assign step          = (state_q == ST_SCAN) && !stall;
  assign last_step     = (idx_q == IdxW'(NUM_TIMERS - 1));
  assign move          = pend_valid_q && out_free &&
                         ((state_q == ST_IDLE) || cand);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (s_axis_tuser == OP_TICK)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step && last_step) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer, timer storage and holding stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      active_q     <= '0;
      mode_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      for (int i = 0; i < int'(NUM_TIMERS); i++) begin
        rem_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      // A new expiry refills the holding stage in the same cycle it empties.
      if (move && !cand) begin
        pend_valid_q <= 1'b0;
      end

      if (accept) begin
        case (s_axis_tuser)
          OP_TICK: begin
            idx_q <= '0;
          end
          OP_START: begin
            if (req_valid) begin
              rem_q[req_idx]    <= load_count;
              mode_q[req_idx]   <= req_mode;
              active_q[req_idx] <= 1'b1;
            end
            pend_valid_q <= 1'b1;
            pend_q       <= '{kind: KIND_START, ok: req_valid, id: req_id,
                              mode: 1'b0, last: 1'b1};
          end
          OP_STOP: begin
            if (req_valid) begin
              active_q[req_idx] <= 1'b0;
            end
            pend_valid_q <= 1'b1;
            pend_q       <= '{kind: KIND_STOP,
                              ok: req_valid && unit_flags.operand_nonzero,
                              id: req_id, mode: 1'b0, last: 1'b1};
          end
          default: begin
            // Unused opcode: no result and no state change.
          end
        endcase
      end

      if (step) begin
        if (scan_act) begin
          rem_q[idx_q] <= unit_diff;
          if (unit_flags.diff_zero) begin
            active_q[idx_q] <= 1'b0;
          end
        end
        if (!last_step) begin
          idx_q <= idx_q + IdxW'(1);
        end
        // The held expiry becomes the final one when the scan ends without
        // a newer expiry.
        if (cand) begin
          pend_valid_q <= 1'b1;
          pend_q       <= '{kind: KIND_EXPIRY, ok: 1'b0, id: IdW'(idx_q),
                            mode: scan_mode, last: last_step};
        end else if (last_step) begin
          pend_q.last <= 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= pend_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.mode, out_q.id, out_q.ok};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

  // A taken tick always starts a scan at the first timer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser == OP_TICK) |=> (state_q == ST_SCAN) && (idx_q == '0))
    else $error("tick transfer did not start a scan");

  // The scan position never leaves the timer range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ({1'b0, idx_q} < (IdxW+1)'(NUM_TIMERS)))
    else $error("scan index out of range");

  // A held result without its last mark only exists during a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q && !pend_q.last |-> (state_q == ST_SCAN))
    else $error("non-final result held outside a scan");

  // Expiry results never carry ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_EXPIRY) |-> !m_axis_tdata[0])
    else $error("expiry result with ok set");

endmodule
